FILE: src/pls_pkg.sv
// Shared types, codes and constants for the point list store.
// Used by every module under src except pls_ram; depends on nothing.
`default_nettype none

package pls_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int COORD_W       = 16;
  localparam int POINT_W       = 2 * COORD_W;
  localparam int SQ_W          = 32;
  localparam int CNT_OUT_W     = 7;
  // Cap on the number of matches reported by one radius search
  localparam int MAX_OUT       = 64;
  localparam int KW            = $clog2(MAX_OUT + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_DELETE = 3'd2,
    OP_RADIUS = 3'd3,
    OP_EXACT  = 3'd4,
    OP_LENGTH = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_MATCH     = 3'd4
  } status_t;

  // Sequencer to distance unit
  typedef struct packed {
    logic valid;
    logic kill;
    logic sel_radius;
  } unit_ctl_t;

  // Distance unit to sequencer
  typedef struct packed {
    logic valid;
    logic eq;
    logic in_range;
  } unit_flags_t;

  // One result transaction
  typedef struct packed {
    logic                        valid;
    status_t                     status;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic                        found;
    logic [CNT_OUT_W-1:0]        count;
    logic                        last;
  } res_t;

  function automatic res_t make_res(input status_t st,
                                    input logic signed [COORD_W-1:0] px,
                                    input logic signed [COORD_W-1:0] py,
                                    input logic fnd,
                                    input logic [CNT_OUT_W-1:0] cnt,
                                    input logic lst);
    res_t r;
    r.valid  = 1'b1;
    r.status = st;
    r.x      = px;
    r.y      = py;
    r.found  = fnd;
    r.count  = cnt;
    r.last   = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/point_list_store_core.sv
// Top level of the point list store: RAM, shared distance unit, sequencer.
// Depends on pls_pkg, pls_ram, pls_dist_unit and pls_seq.
//
// Usage: hold an operation on opcode, coord_x, coord_y and radius and raise
// start; the transaction is taken at a rising edge where start is high and
// busy is low. Results appear on status, point_x, point_y, found,
// entry_count and last for exactly one cycle, marked by result_valid; the
// receiver must take every one of them, there is no way to hold them off.
// Points sit in a ring in RAM, head marking the front entry.
// Insert, remove front, length, and any operation on an empty store give
// their single result in the cycle after acceptance. Exact search and delete
// scan from the front, one entry per cycle through the RAM read port and the
// shared compare unit, and a delete then shifts the entries in front of the
// match back by one. Radius search squares the radius in the shared unit,
// then streams every stored entry through it, giving each match as a result
// and marking the final result last. A delete of the back entry takes the
// longest of all operations.
// Reset empties the store at once; no clearing pass is needed.
`default_nettype none

module point_list_store_core #(
  parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [2:0]                   opcode,
  input  wire logic signed [pls_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [pls_pkg::COORD_W-1:0]  coord_y,
  input  wire logic signed [pls_pkg::COORD_W-1:0]  radius,
  output logic                                     result_valid,
  output logic             [2:0]                   status,
  output logic signed      [pls_pkg::COORD_W-1:0]  point_x,
  output logic signed      [pls_pkg::COORD_W-1:0]  point_y,
  output logic                                     found,
  output logic             [pls_pkg::CNT_OUT_W-1:0] entry_count,
  output logic                                     last
);

  localparam int AW = $clog2(DEPTH);

  logic        [AW-1:0]                 rd_addr;
  logic        [pls_pkg::POINT_W-1:0]   rd_data;
  logic                                 we;
  logic        [AW-1:0]                 wr_addr;
  logic        [pls_pkg::POINT_W-1:0]   wr_data;
  pls_pkg::unit_ctl_t                   uctl;
  pls_pkg::unit_flags_t                 uf;
  logic        [AW-1:0]                 utag;
  logic        [AW-1:0]                 uf_tag;
  logic signed [pls_pkg::COORD_W-1:0]   q_x;
  logic signed [pls_pkg::COORD_W-1:0]   q_y;
  logic signed [pls_pkg::COORD_W-1:0]   q_r;
  logic signed [pls_pkg::COORD_W-1:0]   unit_x;
  logic signed [pls_pkg::COORD_W-1:0]   unit_y;
  logic signed [pls_pkg::COORD_W-1:0]   uf_x;
  logic signed [pls_pkg::COORD_W-1:0]   uf_y;
  logic        [pls_pkg::SQ_W-1:0]      rr;
  logic        [pls_pkg::SQ_W-1:0]      usum;
  pls_pkg::res_t                        res;

  pls_ram #(
    .WIDTH (pls_pkg::POINT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Feed the unit either the stored point or the radius for its squaring pass
  assign unit_x = uctl.sel_radius ? q_r : rd_data[pls_pkg::POINT_W-1:pls_pkg::COORD_W];
  assign unit_y = uctl.sel_radius ? '0  : rd_data[pls_pkg::COORD_W-1:0];

  pls_dist_unit #(
    .TAG_W (AW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .ctl     (uctl),
    .in_x    (unit_x),
    .in_y    (unit_y),
    .q_x     (q_x),
    .q_y     (q_y),
    .tag_in  (utag),
    .rr      (rr),
    .flags   (uf),
    .tag_out (uf_tag),
    .pt_x    (uf_x),
    .pt_y    (uf_y),
    .sum     (usum)
  );

  pls_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .opcode  (opcode),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .radius  (radius),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .uctl    (uctl),
    .utag    (utag),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_r     (q_r),
    .rr      (rr),
    .uf      (uf),
    .uf_tag  (uf_tag),
    .uf_x    (uf_x),
    .uf_y    (uf_y),
    .usum    (usum),
    .res     (res)
  );

  // Unpack the registered result transaction onto the ports
  assign result_valid = res.valid;
  assign status       = res.status;
  assign point_x      = res.x;
  assign point_y      = res.y;
  assign found        = res.found;
  assign entry_count  = res.count;
  assign last         = res.last;

endmodule

`default_nettype wire

FILE: src/pls_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/pls_dist_unit.sv
// Shared compare and distance unit: exact match and squared radius test.
// Depends on pls_pkg.
`default_nettype none

module pls_dist_unit #(
  parameter int TAG_W = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pls_pkg::unit_ctl_t                  ctl,
  input  wire logic signed [pls_pkg::COORD_W-1:0]  in_x,
  input  wire logic signed [pls_pkg::COORD_W-1:0]  in_y,
  input  wire logic signed [pls_pkg::COORD_W-1:0]  q_x,
  input  wire logic signed [pls_pkg::COORD_W-1:0]  q_y,
  input  wire logic        [TAG_W-1:0]             tag_in,
  input  wire logic        [pls_pkg::SQ_W-1:0]     rr,
  output pls_pkg::unit_flags_t                     flags,
  output logic             [TAG_W-1:0]             tag_out,
  output logic signed      [pls_pkg::COORD_W-1:0]  pt_x,
  output logic signed      [pls_pkg::COORD_W-1:0]  pt_y,
  output logic             [pls_pkg::SQ_W-1:0]     sum
);

  logic signed [pls_pkg::SQ_W-1:0] prod_x;
  logic signed [pls_pkg::SQ_W-1:0] prod_y;
  logic        [pls_pkg::SQ_W-1:0] sqx;
  logic        [pls_pkg::SQ_W-1:0] sqy;
  logic                            v1;
  logic                            eq1;

  // Square both coordinates (each is at most 2^30, so it fits in 31 bits)
  assign prod_x = pls_pkg::SQ_W'(in_x) * pls_pkg::SQ_W'(in_x);
  assign prod_y = pls_pkg::SQ_W'(in_y) * pls_pkg::SQ_W'(in_y);

  // Register products, match flag and the point itself
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctl.valid & ~ctl.kill;
    end
    sqx     <= prod_x;
    sqy     <= prod_y;
    eq1     <= (in_x == q_x) && (in_y == q_y);
    tag_out <= tag_in;
    pt_x    <= in_x;
    pt_y    <= in_y;
  end

  // Sum of squares never exceeds 2^31, so no carry is lost
  assign sum            = sqx + sqy;
  assign flags.valid    = v1;
  assign flags.eq       = eq1;
  assign flags.in_range = (sum <= rr);

endmodule

`default_nettype wire

FILE: src/pls_seq.sv
// Sequencer of the point list store: ring pointers, scans, shifts, results.
// Depends on pls_pkg; drives the RAM ports and the shared distance unit.
`default_nettype none

module pls_seq #(
  parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic        [2:0]                    opcode,
  input  wire logic signed [pls_pkg::COORD_W-1:0]   coord_x,
  input  wire logic signed [pls_pkg::COORD_W-1:0]   coord_y,
  input  wire logic signed [pls_pkg::COORD_W-1:0]   radius,
  output logic             [$clog2(DEPTH)-1:0]      rd_addr,
  input  wire logic        [pls_pkg::POINT_W-1:0]   rd_data,
  output logic                                      we,
  output logic             [$clog2(DEPTH)-1:0]      wr_addr,
  output logic             [pls_pkg::POINT_W-1:0]   wr_data,
  output pls_pkg::unit_ctl_t                        uctl,
  output logic             [$clog2(DEPTH)-1:0]      utag,
  output logic signed      [pls_pkg::COORD_W-1:0]   q_x,
  output logic signed      [pls_pkg::COORD_W-1:0]   q_y,
  output logic signed      [pls_pkg::COORD_W-1:0]   q_r,
  output logic             [pls_pkg::SQ_W-1:0]      rr,
  input  wire pls_pkg::unit_flags_t                 uf,
  input  wire logic        [$clog2(DEPTH)-1:0]      uf_tag,
  input  wire logic signed [pls_pkg::COORD_W-1:0]   uf_x,
  input  wire logic signed [pls_pkg::COORD_W-1:0]   uf_y,
  input  wire logic        [pls_pkg::SQ_W-1:0]      usum,
  output pls_pkg::res_t                             res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = pls_pkg::KW;
  localparam int OW = pls_pkg::CNT_OUT_W;
  localparam logic [KW-1:0] KMAX = KW'(pls_pkg::MAX_OUT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RLOAD,
    S_RWAIT,
    S_RLAST,
    S_SHIFT
  } state_t;

  state_t                               state;
  pls_pkg::op_t                         op;
  logic        [AW-1:0]                 head;
  logic        [CW-1:0]                 count;
  logic        [CW-1:0]                 iss_idx;
  logic                                 issue_d;
  logic        [KW-1:0]                 k;
  logic                                 pend_valid;
  logic signed [pls_pkg::COORD_W-1:0]   pend_x;
  logic signed [pls_pkg::COORD_W-1:0]   pend_y;
  logic        [AW-1:0]                 sh;
  logic                                 shw_valid;
  logic        [AW-1:0]                 shw_idx;

  logic        [AW-1:0]                 head_inc;
  logic        [AW-1:0]                 head_dec;
  logic                                 ins_go;
  logic                                 tag_last;
  logic        [OW-1:0]                 cnt_now;
  logic        [OW-1:0]                 cnt_up;
  logic        [OW-1:0]                 cnt_dn;

  // Logical position to physical RAM address on the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, hd} + {1'b0, l};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign busy     = (state != S_IDLE);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign tag_last = (CW'(uf_tag) == count - CW'(1));
  assign cnt_now  = OW'(count);
  assign cnt_up   = OW'(count + CW'(1));
  assign cnt_dn   = OW'(count - CW'(1));

  // Front insert goes straight to the RAM at the accepting edge
  assign ins_go = (state == S_IDLE) && start &&
                  (opcode == pls_pkg::OP_INSERT) && (count < CW'(DEPTH));

  // RAM ports: shift writes take priority, they never overlap an insert
  always_comb begin
    rd_addr = phys(head, iss_idx[AW-1:0]);
    if (state == S_SHIFT) begin
      rd_addr = phys(head, sh - AW'(1));
    end
    we      = ins_go || shw_valid;
    wr_addr = shw_valid ? phys(head, shw_idx) : head_dec;
    wr_data = shw_valid ? rd_data : {coord_x, coord_y};
  end

  // Unit control: radius squaring pass, then one entry per cycle
  assign uctl.valid      = (state == S_RLOAD) || issue_d;
  assign uctl.kill       = (state != S_SCAN) && (state != S_RLOAD);
  assign uctl.sel_radius = (state == S_RLOAD);

  // Sequencer state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      iss_idx    <= '0;
      issue_d    <= 1'b0;
      k          <= '0;
      pend_valid <= 1'b0;
      shw_valid  <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      issue_d   <= 1'b0;
      case (state)
        S_IDLE: begin
          shw_valid <= 1'b0;
          if (start) begin
            op  <= pls_pkg::op_t'(opcode);
            q_x <= coord_x;
            q_y <= coord_y;
            q_r <= radius;
            iss_idx    <= '0;
            k          <= '0;
            pend_valid <= 1'b0;
            case (opcode)
              pls_pkg::OP_INSERT: begin
                if (ins_go) begin
                  head  <= head_dec;
                  count <= count + CW'(1);
                  res   <= pls_pkg::make_res(pls_pkg::ST_OK, '0, '0, 1'b0, cnt_up, 1'b1);
                end else begin
                  res <= pls_pkg::make_res(pls_pkg::ST_FULL, '0, '0, 1'b0, cnt_now, 1'b1);
                end
              end
              pls_pkg::OP_REMOVE: begin
                if (count == '0) begin
                  res <= pls_pkg::make_res(pls_pkg::ST_EMPTY, '0, '0, 1'b0, cnt_now, 1'b1);
                end else begin
                  head  <= head_inc;
                  count <= count - CW'(1);
                  res   <= pls_pkg::make_res(pls_pkg::ST_OK, '0, '0, 1'b0, cnt_dn, 1'b1);
                end
              end
              pls_pkg::OP_DELETE: begin
                if (count == '0) begin
                  res <= pls_pkg::make_res(pls_pkg::ST_NOT_FOUND, '0, '0, 1'b0, cnt_now,
                                           1'b1);
                end else begin
                  state <= S_SCAN;
                end
              end
              pls_pkg::OP_RADIUS: begin
                if (count == '0) begin
                  res <= pls_pkg::make_res(pls_pkg::ST_EMPTY, '0, '0, 1'b0, cnt_now, 1'b1);
                end else if (radius < 0) begin
                  res <= pls_pkg::make_res(pls_pkg::ST_NOT_FOUND, '0, '0, 1'b0, cnt_now,
                                           1'b1);
                end else begin
                  state <= S_RLOAD;
                end
              end
              pls_pkg::OP_EXACT: begin
                if (count == '0) begin
                  res <= pls_pkg::make_res(pls_pkg::ST_OK, '0, '0, 1'b0, cnt_now, 1'b1);
                end else begin
                  state <= S_SCAN;
                end
              end
              pls_pkg::OP_LENGTH: begin
                res <= pls_pkg::make_res(pls_pkg::ST_OK, '0, '0, 1'b0, cnt_now, 1'b1);
              end
              default: begin
                // Undefined codes: drop silently
              end
            endcase
          end
        end
        S_RLOAD: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          // Squared radius comes out of the shared unit
          rr    <= usum;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // Issue one read per cycle until every entry is out
          if (iss_idx < count) begin
            issue_d <= 1'b1;
            utag    <= iss_idx[AW-1:0];
            iss_idx <= iss_idx + CW'(1);
          end
          if (uf.valid) begin
            case (op)
              pls_pkg::OP_EXACT: begin
                if (uf.eq) begin
                  res   <= pls_pkg::make_res(pls_pkg::ST_OK, '0, '0, 1'b1, cnt_now, 1'b1);
                  state <= S_IDLE;
                end else if (tag_last) begin
                  res   <= pls_pkg::make_res(pls_pkg::ST_OK, '0, '0, 1'b0, cnt_now, 1'b1);
                  state <= S_IDLE;
                end
              end
              pls_pkg::OP_DELETE: begin
                if (uf.eq) begin
                  sh    <= uf_tag;
                  state <= S_SHIFT;
                end else if (tag_last) begin
                  res   <= pls_pkg::make_res(pls_pkg::ST_NOT_FOUND, '0, '0, 1'b0, cnt_now,
                                             1'b1);
                  state <= S_IDLE;
                end
              end
              pls_pkg::OP_RADIUS: begin
                // Hold each match back one step so the final one can be marked
                if (uf.in_range && (k < KMAX)) begin
                  k <= k + KW'(1);
                  if (pend_valid) begin
                    res <= pls_pkg::make_res(pls_pkg::ST_MATCH, pend_x, pend_y, 1'b0,
                                             cnt_now, 1'b0);
                  end
                  pend_valid <= 1'b1;
                  pend_x     <= uf_x;
                  pend_y     <= uf_y;
                end
                if (tag_last) begin
                  state <= S_RLAST;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RLAST: begin
          if (pend_valid) begin
            res <= pls_pkg::make_res(pls_pkg::ST_MATCH, pend_x, pend_y, 1'b0, cnt_now, 1'b1);
          end else begin
            res <= pls_pkg::make_res(pls_pkg::ST_NOT_FOUND, '0, '0, 1'b0, cnt_now, 1'b1);
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        S_SHIFT: begin
          // Move the entries in front of the hole back by one, then advance head
          if (sh != '0) begin
            shw_valid <= 1'b1;
            shw_idx   <= sh;
            sh        <= sh - AW'(1);
          end else begin
            shw_valid <= 1'b0;
            head      <= head_inc;
            count     <= count - CW'(1);
            res       <= pls_pkg::make_res(pls_pkg::ST_OK, '0, '0, 1'b0, cnt_dn, 1'b1);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Fill level and ring pointer stay in range
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(DEPTH)) && (head < AW'(DEPTH - 1) || head == AW'(DEPTH - 1)))
    else $error("point list store: count or head out of range");

  // Fill level moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                     count == $past(count) - CW'(1)))
    else $error("point list store: count jumped");

  // The final result of a transaction leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last) |-> (state == S_IDLE))
    else $error("point list store: final result while still busy");

  // Intermediate search results only while a scan is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last) |-> busy)
    else $error("point list store: intermediate result while idle");

endmodule

`default_nettype wire
